>>> hw/rtl/btm3_pkg.sv
package btm3_pkg;

    // Fixed geometry of the morphology window.
    localparam int WINDOW_SIZE = 3;
    localparam int LINE_COUNT  = WINDOW_SIZE - 1;
    localparam int WIN_BITS    = WINDOW_SIZE * WINDOW_SIZE;

    // Field widths.
    localparam int PIX_W       = 8;
    localparam int THRESH_W    = 9;
    localparam int MODE_W      = 2;
    localparam int IMG_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // Output pixel levels.
    localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;
    localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd2;

    // Register reset values.
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 9'd100;
    localparam logic [MODE_W-1:0]   MODE_RESET      = MODE_ERODE;
    localparam logic [IMG_W-1:0]    WIDTH_RESET     = 12'd640;

    // Smallest image width in use.
    localparam int MIN_WIDTH = 3;

    // Row counter saturation value.
    localparam logic [1:0] ROWS_FULL = 2'd2;

    // Binary pixel and frame mark handed from cell to cell.
    typedef struct packed {
        logic pix;
        logic start;
    } btm3_tok_t;

    // Per-cell operation: dilate or erode, or pass the incoming pixel on.
    typedef struct packed {
        logic dilate;
        logic bypass;
    } btm3_mode_t;

endpackage

>>> hw/rtl/btm3_pix_if.sv
interface btm3_pix_if;
    import btm3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gray_pixel;
    logic             frame_start;

    modport source (output valid, output gray_pixel, output frame_start, input ready);
    modport sink (input valid, input gray_pixel, input frame_start, output ready);

endinterface

>>> hw/rtl/btm3_res_if.sv
interface btm3_res_if;
    import btm3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;

    modport source (output valid, output result_pixel, input ready);
    modport sink (input valid, input result_pixel, output ready);

endinterface

>>> hw/rtl/binary_threshold_morphology_3x3.sv
// Channel   Direction  Transaction payload
// pixels    in         gray_pixel (8 bits), frame_start (1 bit)
// results   out        result_pixel (8 bits), 0 or 255
// cfg       in         cfg_we, cfg_index (2 bits), cfg_data (12 bits)
//
// One pixel is accepted in every cycle but in the stalls named below; each
// of the two morphology cells has one output register on a result's path.
// The rate is set by the line-store RAM of each cell, which is read one
// column ahead and written at the current column in the same cycle.
// Reset clears the counters, windows and valid flags; line stores are not
// cleared. A stalled result holds in the last cell and the input stalls in
// the same cycle, unless the first cell's register is empty, in which case
// it takes one more pixel first. After a width write, a pixel without a
// frame mark may wait while the line-store read is repeated.
module binary_threshold_morphology_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    btm3_pix_if.sink                            pixels,
    btm3_res_if.source                          results,
    input  logic                                cfg_we,
    input  logic [btm3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [btm3_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btm3_pkg::*;

    localparam int W_W   = $clog2(MAX_WIDTH) + 1;
    localparam int CMP_W = (W_W > IMG_W) ? W_W : IMG_W;

    logic [THRESH_W-1:0] threshold_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [IMG_W-1:0]    image_width_reg;

    logic [CMP_W-1:0]    width_ext;
    logic [W_W-1:0]      width;
    logic                first_dilate;
    btm3_mode_t          mode1;
    btm3_mode_t          mode2;
    btm3_tok_t           bin_tok;
    logic                mid_valid;
    logic                mid_ready;
    btm3_tok_t           mid_tok;
    btm3_tok_t           last_tok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            mode_reg        <= MODE_RESET;
            image_width_reg <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg   <= cfg_data[THRESH_W-1:0];
                REG_MODE:      mode_reg        <= cfg_data[MODE_W-1:0];
                REG_WIDTH:     image_width_reg <= cfg_data[IMG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Width in use, clamped to the supported range.
    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(MIN_WIDTH))
        begin
            width = W_W'(MIN_WIDTH);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            width = W_W'(MAX_WIDTH);
        end
        else
        begin
            width = W_W'(width_ext);
        end
    end

    // The second cell always does the opposite of the first one and
    // passes the first cell's result on in the single-pass modes.
    assign first_dilate = (mode_reg == MODE_DILATE) || (mode_reg == MODE_CLOSE);
    assign mode1.dilate = first_dilate;
    assign mode1.bypass = 1'b0;
    assign mode2.dilate = !first_dilate;
    assign mode2.bypass = (mode_reg == MODE_ERODE) || (mode_reg == MODE_DILATE);

    // Binarize: at or above the threshold gives a zero pixel.
    assign bin_tok.pix   = ({1'b0, pixels.gray_pixel} < threshold_reg);
    assign bin_tok.start = pixels.frame_start;

    btm3_cell #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cell1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .in_ready  (pixels.ready),
        .in_tok    (bin_tok),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_tok   (mid_tok),
        .width     (width),
        .mode      (mode1)
    );

    btm3_cell #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cell2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_tok    (mid_tok),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_tok   (last_tok),
        .width     (width),
        .mode      (mode2)
    );

    // Expand the binary result to a gray level.
    assign results.result_pixel = last_tok.pix ? PIX_HIGH : PIX_LOW;

endmodule

>>> hw/rtl/btm3_ram.sv
module btm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/btm3_cell.sv
module btm3_cell #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  btm3_pkg::btm3_tok_t        in_tok,
    output logic                       out_valid,
    input  logic                       out_ready,
    output btm3_pkg::btm3_tok_t        out_tok,
    input  logic [$clog2(MAX_WIDTH):0] width,
    input  btm3_pkg::btm3_mode_t       mode
);
    import btm3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int W_W    = ADDR_W + 1;

    logic [ADDR_W-1:0]     col_reg;
    logic [ADDR_W-1:0]     col_next;
    logic [1:0]            rows_reg;
    logic [1:0]            rows_next;
    logic [WIN_BITS-1:0]   win_reg;
    logic [WIN_BITS-1:0]   win_next;
    logic                  out_valid_reg;
    btm3_tok_t             out_tok_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [ADDR_W-1:0]     rd_addr_next;

    logic                  fire;
    logic [ADDR_W-1:0]     col_hold;
    logic                  rd_ok;
    logic [ADDR_W-1:0]     col;
    logic [1:0]            rows;
    logic [W_W-1:0]        col_inc;
    logic                  wrap;
    logic [LINE_COUNT-1:0] line_rd;
    logic                  up1;
    logic                  up2;
    logic [2:0]            col_mask;
    logic [WIN_BITS-1:0]   win_valid;
    logic                  hit;
    logic                  res_bit;

    // Column that the next pixel takes when it carries no frame mark.
    assign col_hold = ({1'b0, col_reg} >= width) ? '0 : col_reg;

    // The line-store data is usable when it was read at the pixel's column.
    // A frame start needs no line data, since its first row is masked.
    assign rd_ok    = (in_valid && in_tok.start) || (rd_addr_reg == col_hold);
    assign in_ready = (!out_valid_reg || out_ready) && rd_ok;
    assign fire     = in_valid && in_ready;

    // Line stores: bit 0 holds the row above, bit 1 the row two above.
    // The read for the next column is issued with each transaction, so the
    // data is waiting in the read register when the next pixel arrives.
    // While no transaction happens, the column the next pixel takes is read
    // again, so after a width change a pixel waits only for that repeated read.
    assign rd_addr_next = fire ? col_next : col_hold;

    btm3_ram #(
        .WIDTH (LINE_COUNT),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (fire),
        .waddr (col),
        .wdata ({up1, in_tok.pix}),
        .re    (1'b1),
        .raddr (rd_addr_next),
        .rdata (line_rd)
    );

    // Position of the current pixel; a frame start clears both counters.
    always_comb
    begin
        if (in_tok.start)
        begin
            col  = '0;
            rows = '0;
        end
        else
        begin
            col  = col_hold;
            rows = rows_reg;
        end
    end

    // Column and row advance.
    always_comb
    begin
        col_inc   = {1'b0, col} + W_W'(1);
        wrap      = (col_inc >= width);
        col_next  = wrap ? '0 : col_inc[ADDR_W-1:0];
        rows_next = (wrap && (rows != ROWS_FULL)) ? rows + 2'd1 : rows;
    end

    // Shift the new column into the window; bit 0 of each row is the
    // current column, rows run from two above to the current one.
    assign up1      = line_rd[0];
    assign up2      = line_rd[1];
    assign win_next = {win_reg[7:6], in_tok.pix,
                       win_reg[4:3], up1,
                       win_reg[1:0], up2};

    // Mask of window positions that lie inside the image.
    always_comb
    begin
        col_mask  = {(col >= ADDR_W'(2)), (col >= ADDR_W'(1)), 1'b1};
        win_valid = {col_mask,
                     (rows >= 2'd1) ? col_mask : 3'b000,
                     (rows >= 2'd2) ? col_mask : 3'b000};
    end

    // Maximum or minimum over the valid positions.
    always_comb
    begin
        if (mode.dilate)
        begin
            hit = |(win_next & win_valid);
        end
        else
        begin
            hit = ((win_next & win_valid) == win_valid);
        end
        res_bit = mode.bypass ? in_tok.pix : hit;
    end

    // Cell state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            rows_reg      <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            if (fire)
            begin
                col_reg       <= col_next;
                rows_reg      <= rows_next;
                win_reg       <= win_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_tok_reg.pix   <= res_bit;
            out_tok_reg.start <= in_tok.start;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

>>> hw/rtl/btm3_checker.sv
module btm3_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [btm3_pkg::PIX_W-1:0] result_pixel
);
    import btm3_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_pixel))
        else $error("result changed while stalled");

    // Every result is a pure binary level.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_pixel == PIX_LOW) || (result_pixel == PIX_HIGH))
        else $error("result is not a binary level");

    // An offered pixel only stalls behind a stalled result or right after a
    // configuration write.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> (out_valid && !out_ready) || $past(cfg_we))
        else $error("input stalled with no stalled output transaction");

endmodule

bind binary_threshold_morphology_3x3 btm3_checker u_btm3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .in_valid     (pixels.valid),
    .in_ready     (pixels.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .result_pixel (results.result_pixel)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import btm3_pkg::*;

    localparam int LINE_DEPTH       = 2048;
    localparam int RANDOM_PIXELS    = 700;
    localparam int WIDE_PIXELS      = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    btm3_pix_if pix_bus ();
    btm3_res_if res_bus ();

    binary_threshold_morphology_3x3 #(
        .MAX_WIDTH(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pixels(pix_bus),
        .results(res_bus),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Register copies used by the predictor.
    logic [THRESH_W-1:0] thr_reg   = THRESHOLD_RESET;
    logic [MODE_W-1:0]   mode_reg  = MODE_RESET;
    logic [IMG_W-1:0]    width_reg = WIDTH_RESET;

    // Predictor state of both cascaded stages.
    bit                  line_prev  [2][LINE_DEPTH];
    bit                  line_prev2 [2][LINE_DEPTH];
    logic [WIN_BITS-1:0] stage_win  [2] = '{default: '0};
    int unsigned         stage_col  [2] = '{default: 0};
    int unsigned         stage_rows [2] = '{default: 0};

    logic [PIX_W-1:0] expected_pixels [$];
    logic [PIX_W-1:0] expected_now;

    int  pixels_sent     = 0;
    int  results_checked = 0;
    int  setups_used     = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    bit  quiet_mode      = 1'b0;
    bit  long_hold_pending = 1'b0;
    bit  run_level       = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Width that the block actually uses.
    function automatic int unsigned active_width();
        if (width_reg < MIN_WIDTH)
            return MIN_WIDTH;
        if (width_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(width_reg);
    endfunction

    // One 3x3 stage: shift the window, update the line stores, and reduce the
    // part of the window that lies inside the image.
    function automatic bit morph_stage(input int s, input bit px, input bit restart,
                                       input bit grow);
        int unsigned         w;
        int unsigned         c;
        bit                  up1;
        bit                  up2;
        logic [2:0]          cols_in;
        logic [WIN_BITS-1:0] span;
        logic [WIN_BITS-1:0] win;
        w = active_width();
        if (restart)
        begin
            stage_col[s]  = 0;
            stage_rows[s] = 0;
        end
        if (stage_col[s] >= w)
            stage_col[s] = 0;
        c   = stage_col[s];
        up1 = line_prev[s][c];
        up2 = line_prev2[s][c];
        win = {stage_win[s][7:6], px, stage_win[s][4:3], up1, stage_win[s][1:0], up2};
        stage_win[s] = win;
        line_prev2[s][c] = up1;
        line_prev[s][c]  = px;
        cols_in = (c >= 2) ? 3'b111 : (c >= 1) ? 3'b011 : 3'b001;
        span = {cols_in,
                (stage_rows[s] >= 1) ? cols_in : 3'b000,
                (stage_rows[s] >= 2) ? cols_in : 3'b000};
        stage_col[s] = c + 1;
        if (stage_col[s] >= w)
        begin
            stage_col[s] = 0;
            if (stage_rows[s] < 2)
                stage_rows[s]++;
        end
        if (grow)
            return |(win & span);
        return (win & span) == span;
    endfunction

    // Binarize one gray pixel, run it through both stages, queue the result.
    task automatic predict_morphology(input logic [PIX_W-1:0] gray, input bit restart);
        bit fg;
        bit first_grows;
        bit s1;
        bit s2;
        bit outcome;
        fg = ({1'b0, gray} >= thr_reg) ? 1'b0 : 1'b1;
        first_grows = (mode_reg == MODE_DILATE) || (mode_reg == MODE_CLOSE);
        s1 = morph_stage(0, fg, restart, first_grows);
        s2 = morph_stage(1, s1, restart, !first_grows);
        outcome = (mode_reg == MODE_OPEN || mode_reg == MODE_CLOSE) ? s2 : s1;
        expected_pixels.insert(expected_pixels.size(), outcome ? PIX_HIGH : PIX_LOW);
    endtask

    // Configuration write; only called while nothing is in flight.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg   = value[THRESH_W-1:0];
            REG_MODE:      mode_reg  = value[MODE_W-1:0];
            REG_WIDTH:     width_reg = value[IMG_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one pixel and hold it until the block takes it. Valid stays high on
    // return so back-to-back transactions follow without an idle gap.
    task automatic send_pixel(input logic [PIX_W-1:0] gray, input bit restart);
        while (!quiet_mode && $urandom_range(0, 99) < 18)
        begin
            pix_bus.valid = 1'b0;
            @(negedge clk);
        end
        pix_bus.valid       = 1'b1;
        pix_bus.gray_pixel  = gray;
        pix_bus.frame_start = restart;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        predict_morphology(gray, restart);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic wait_all_results();
        pix_bus.valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    // Gray values in runs on either side of the threshold, with some noise,
    // so that both erosion and dilation produce both levels.
    function automatic logic [PIX_W-1:0] blob_gray();
        logic [PIX_W-1:0] g;
        if ($urandom_range(0, 99) < 20)
            run_level = ~run_level;
        if ($urandom_range(0, 99) < 12)
            g = PIX_W'($urandom_range(0, 255));
        else if (run_level && thr_reg > 0)
            g = PIX_W'($urandom_range(0, (thr_reg > 255) ? 255 : thr_reg - 1));
        else if (!run_level && thr_reg <= 255)
            g = PIX_W'($urandom_range(thr_reg, 255));
        else
            g = PIX_W'($urandom_range(0, 255));
        return g;
    endfunction

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(blob_gray(), i == 0);
    endtask

    // Pick new register values; each register is rewritten most of the time.
    task automatic random_setup();
        logic [THRESH_W-1:0] t;
        logic [IMG_W-1:0]    w;
        logic [2:0]          junk3;
        logic [9:0]          junk10;
        junk3  = 3'($urandom_range(0, 7));
        junk10 = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 9))
                0: t = 9'd0;
                1: t = 9'd256;
                2: t = 9'd255;
                3: t = 9'd1;
                4: t = THRESH_W'($urandom_range(257, 511));
                default: t = THRESH_W'($urandom_range(30, 230));
            endcase
            write_register(REG_THRESHOLD, {junk3, t});
        end
        if ($urandom_range(0, 9) < 7)
            write_register(REG_MODE, {junk10, 2'($urandom_range(0, 3))});
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 9))
                6: w = IMG_W'($urandom_range(0, 2));
                7, 8: w = IMG_W'($urandom_range(13, 40));
                9: w = IMG_W'(MIN_WIDTH);
                default: w = IMG_W'($urandom_range(3, 12));
            endcase
            write_register(REG_WIDTH, w);
        end
        setups_used++;
    endtask

    // Right after reset, with the reset register values and no frame mark.
    task automatic test_reset_state();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd99, 1'b0);
        wait_all_results();
    endtask

    // Every operation on a clamped narrow image, with threshold extremes and
    // a frame restart at the start of the second row in close mode.
    task automatic test_modes_and_clamp();
        logic [MODE_W-1:0]   modes [4];
        logic [THRESH_W-1:0] thrs  [4];
        logic [PIX_W-1:0]    grays [5];
        modes = '{MODE_ERODE, MODE_DILATE, MODE_OPEN, MODE_CLOSE};
        thrs  = '{9'd128, 9'd256, 9'd0, 9'd255};
        grays = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd200};
        write_register(REG_WIDTH, 12'd1);
        for (int m = 0; m < 4; m++)
        begin
            write_register(REG_MODE, {{(CFG_DATA_W-MODE_W){1'b0}}, modes[m]});
            write_register(REG_THRESHOLD, {{(CFG_DATA_W-THRESH_W){1'b0}}, thrs[m]});
            for (int i = 0; i < 5; i++)
                send_pixel(grays[i], (i == 0) || (modes[m] == MODE_CLOSE && i == 3));
            wait_all_results();
            setups_used++;
        end
    endtask

    // Random settings and frames; one stretch runs with no idling at all.
    task automatic test_random_frames();
        int first;
        int frames;
        int w;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_PIXELS)
        begin
            wait_all_results();
            quiet_mode = (pixels_sent - first >= 300) && (pixels_sent - first < 450);
            random_setup();
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                w = active_width();
                send_frame(w * $urandom_range(0, 4) + $urandom_range(1, w));
            end
        end
        quiet_mode = 1'b0;
        wait_all_results();
    endtask

    // The receiver holds off for a long time while pixels keep coming, so the
    // block fills up and stalls its input.
    task automatic test_output_backpressure();
        write_register(REG_WIDTH, 12'd5);
        write_register(REG_MODE, {10'd0, MODE_CLOSE});
        write_register(REG_THRESHOLD, 12'd140);
        setups_used++;
        long_hold_pending = 1'b1;
        send_frame(60);
        wait_all_results();
    endtask

    // A width far above the limit: the frame stays within one clamped row.
    task automatic test_widest_rows();
        write_register(REG_WIDTH, 12'hFFF);
        write_register(REG_MODE, {10'd0, MODE_OPEN});
        write_register(REG_THRESHOLD, 12'd128);
        send_frame(WIDE_PIXELS);
        wait_all_results();
        setups_used++;
    endtask

    // Result side: random stalls, plus one long hold-off when requested.
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                res_bus.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            res_bus.ready = rst_n && (quiet_mode || $urandom_range(0, 99) >= 18);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result %0d, expected nothing", $realtime,
                         res_bus.result_pixel);
            end
            else
            begin
                expected_now = expected_pixels.pop_front();
                results_checked++;
                if (res_bus.result_pixel !== expected_now)
                begin
                    error_count++;
                    $display("%0t: result_pixel mismatch, expected %0d, actual %0d",
                             $realtime, expected_now, res_bus.result_pixel);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                     expected_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.gray_pixel  = '0;
        pix_bus.frame_start = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_modes_and_clamp();
        test_random_frames();
        test_output_backpressure();
        test_widest_rows();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_pixels.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     expected_pixels.size());
        end

        $display("Sent %0d pixels and checked %0d results over %0d register settings,",
                 pixels_sent, results_checked, setups_used);
        $display("covering all four operations, narrow, clamped and oversized widths,");
        $display("frame restarts mid-row and a long output stall.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/btm3_pkg.sv
hw/rtl/btm3_pix_if.sv
hw/rtl/btm3_res_if.sv
hw/rtl/btm3_ram.sv
hw/rtl/btm3_cell.sv
hw/rtl/binary_threshold_morphology_3x3.sv
hw/rtl/btm3_checker.sv
tb/testbench.sv
